/* src/aa_circle_outline_column_top_macros.svh */
// assertion macros shared by the circle outline column block
`ifndef AA_CIRCLE_OUTLINE_COLUMN_TOP_MACROS_SVH
`define AA_CIRCLE_OUTLINE_COLUMN_TOP_MACROS_SVH

// same-cycle implication, clocked on aclk, off while aresetn is low
`define AACOL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while aresetn is low
`define AACOL_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/aacol_pkg.sv */
// shared constants for the circle outline column block
package aacol_pkg;

    localparam int DEF_RADIUS_INT_BITS  = 10;
    localparam int DEF_RADIUS_FRAC_BITS = 8;
    localparam int DEF_COORD_BITS       = 16;

    localparam int COL_W     = 10;
    localparam int ALPHA_W   = 8;
    localparam int ALPHA_MAX = 255;
    localparam int BEATS     = 16;
    localparam int BEAT_W    = 4;

endpackage

/* src/aa_circle_outline_column_top.sv */
// top level of the anti-aliased circle outline column block
// a request passes stage 1, stage 2, the square root stages and stage 3 before the output serializer
// each column inside the octant gives 16 pixels, one per cycle on the single result port while m_tready is high
// so a new column loads only as the last pixel of the previous one is taken; a column past the stop uses one slot
// the square root is one pipeline stage per result bit and takes a new column every cycle unless the pipeline stalls
// aresetn is synchronous, active low, and clears the valid bits and the pixel counter
`include "aa_circle_outline_column_top_macros.svh"

module aa_circle_outline_column_top #(
    parameter int RADIUS_INT_BITS  = aacol_pkg::DEF_RADIUS_INT_BITS,
    parameter int RADIUS_FRAC_BITS = aacol_pkg::DEF_RADIUS_FRAC_BITS,
    parameter int COORD_BITS       = aacol_pkg::DEF_COORD_BITS,
    localparam int RB              = RADIUS_INT_BITS + RADIUS_FRAC_BITS,
    localparam int OUT_W           = COORD_BITS + 1,
    localparam int IN_PK_W         = 2 * COORD_BITS + RB + aacol_pkg::COL_W,
    localparam int IN_TD_W         = ((IN_PK_W + 7) / 8) * 8,
    localparam int OUT_PK_W        = 2 * OUT_W + aacol_pkg::ALPHA_W,
    localparam int OUT_TD_W        = ((OUT_PK_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // center_x, center_y, radius, column
    input  logic [IN_TD_W-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // pixel_x, pixel_y, coverage
    output logic [OUT_TD_W-1:0] m_tdata,
    // final_column
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int CB     = COORD_BITS;
    localparam int RF     = RADIUS_FRAC_BITS;
    localparam int RI     = RADIUS_INT_BITS;
    localparam int CW     = aacol_pkg::COL_W;
    localparam int AW     = aacol_pkg::ALPHA_W;
    localparam int BW     = aacol_pkg::BEAT_W;
    localparam int TW     = CW + 1;
    localparam int CMP_A  = (2 * RB > 2 * TW + 2 * RF - 1) ? 2 * RB : 2 * TW + 2 * RF - 1;
    localparam int CMP_B  = (CMP_A > 2 * CW + 2 * RF) ? CMP_A : 2 * CW + 2 * RF;
    localparam int CMP_W  = CMP_B + 1;
    localparam int ARI_A  = (OUT_W > RI + 1) ? OUT_W : RI + 1;
    localparam int ARI_W  = (ARI_A > CW) ? ARI_A : CW;
    localparam logic [BW-1:0] LAST_BEAT = BW'(aacol_pkg::BEATS - 1);

    // input unpack
    logic [CB-1:0] in_cx, in_cy;
    logic [RB-1:0] in_rad;
    logic [CW-1:0] in_col;
    logic [TW-1:0] in_t0, in_t1;

    assign in_cx  = s_tdata[CB-1:0];
    assign in_cy  = s_tdata[2*CB-1:CB];
    assign in_rad = s_tdata[2*CB+RB-1:2*CB];
    assign in_col = s_tdata[2*CB+RB+CW-1:2*CB+RB];
    assign in_t0  = {in_col, 1'b0} - TW'(1);
    assign in_t1  = {in_col, 1'b1};

    logic en;
    logic tail_take, ser_free, load, out_fire;

    // stage 1: squares
    logic            v1_reg;
    logic [CB-1:0]   cx1_reg, cy1_reg;
    logic [CW-1:0]   col1_reg;
    logic [2*RB-1:0] rsq1_reg;
    logic [2*CW-1:0] colsq1_reg;
    logic [2*TW-1:0] t0sq1_reg, t1sq1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx1_reg    <= in_cx;
            cy1_reg    <= in_cy;
            col1_reg   <= in_col;
            rsq1_reg   <= in_rad * in_rad;
            colsq1_reg <= in_col * in_col;
            t0sq1_reg  <= in_t0 * in_t0;
            t1sq1_reg  <= in_t1 * in_t1;
        end
    end

    // stage 2: stop test and radicand
    logic [CMP_W-1:0] rsq_w, sub_w, stop0_w, stop1_w, rc_w;
    logic             in_stop, past_next;

    assign rsq_w     = CMP_W'(rsq1_reg);
    assign sub_w     = CMP_W'(colsq1_reg) << (2 * RF);
    assign stop0_w   = CMP_W'(t0sq1_reg) << (2 * RF - 1);
    assign stop1_w   = CMP_W'(t1sq1_reg) << (2 * RF - 1);
    assign in_stop   = (col1_reg == '0) || (stop0_w <= rsq_w);
    assign past_next = !(stop1_w <= rsq_w);
    assign rc_w      = (rsq_w > sub_w) ? (rsq_w - sub_w) : '0;

    logic            v2_reg, skip2_reg, fin2_reg;
    logic [CB-1:0]   cx2_reg, cy2_reg;
    logic [CW-1:0]   col2_reg;
    logic [2*RB-1:0] rc2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            skip2_reg <= !in_stop;
            fin2_reg  <= past_next;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            col2_reg  <= col1_reg;
            rc2_reg   <= rc_w[2*RB-1:0];
        end
    end

    // square root stages
    logic [RB:0]     rem_i  [0:RB-1];
    logic [RB-1:0]   root_i [0:RB-1];
    logic [2*RB-1:0] rad_i  [0:RB-1];
    logic [RB:0]     rem_o  [0:RB-1];
    logic [RB-1:0]   root_o [0:RB-1];
    logic [2*RB-1:0] rad_o  [0:RB-1];

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        if (k == 0) begin : g_head
            assign rem_i[k]  = '0;
            assign root_i[k] = '0;
            assign rad_i[k]  = rc2_reg;
        end else begin : g_body
            assign rem_i[k]  = rem_o[k-1];
            assign root_i[k] = root_o[k-1];
            assign rad_i[k]  = rad_o[k-1];
        end
        aacol_sqrt_step #(
            .ROOT_W(RB)
        ) u_step (
            .aclk    (aclk),
            .en      (en),
            .rem_in  (rem_i[k]),
            .root_in (root_i[k]),
            .rad_in  (rad_i[k]),
            .rem_out (rem_o[k]),
            .root_out(root_o[k]),
            .rad_out (rad_o[k])
        );
    end

    logic [RB-1:0] sv_reg, sskip_reg, sfin_reg;
    logic [CB-1:0] scx_reg  [0:RB-1];
    logic [CB-1:0] scy_reg  [0:RB-1];
    logic [CW-1:0] scol_reg [0:RB-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg <= '0;
        end else if (en) begin
            sv_reg <= {sv_reg[RB-2:0], v2_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sskip_reg   <= {sskip_reg[RB-2:0], skip2_reg};
            sfin_reg    <= {sfin_reg[RB-2:0], fin2_reg};
            scx_reg[0]  <= cx2_reg;
            scy_reg[0]  <= cy2_reg;
            scol_reg[0] <= col2_reg;
            for (int k = 1; k < RB; k++) begin
                scx_reg[k]  <= scx_reg[k-1];
                scy_reg[k]  <= scy_reg[k-1];
                scol_reg[k] <= scol_reg[k-1];
            end
        end
    end

    // stage 3: split root, coverage
    logic [RB-1:0]   root_y;
    logic [RF-1:0]   frac;
    logic [RF:0]     one_m_f;
    logic [RF+8:0]   in_scaled, out_scaled;

    assign root_y     = root_o[RB-1];
    assign frac       = root_y[RF-1:0];
    assign one_m_f    = (RF+1)'(1 << RF) - {1'b0, frac};
    assign in_scaled  = ((RF+9)'(one_m_f) << 8) - (RF+9)'(one_m_f);
    assign out_scaled = ((RF+9)'(frac) << 8) - (RF+9)'(frac);

    logic          v3_reg, skip3_reg, fin3_reg;
    logic [CB-1:0] cx3_reg, cy3_reg;
    logic [CW-1:0] col3_reg;
    logic [RI-1:0] ip3_reg;
    logic [AW-1:0] ain3_reg, aout3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= sv_reg[RB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            skip3_reg <= sskip_reg[RB-1];
            fin3_reg  <= sfin_reg[RB-1];
            cx3_reg   <= scx_reg[RB-1];
            cy3_reg   <= scy_reg[RB-1];
            col3_reg  <= scol_reg[RB-1];
            ip3_reg   <= root_y[RB-1:RF];
            ain3_reg  <= in_scaled[RF+AW-1:RF];
            aout3_reg <= out_scaled[RF+AW-1:RF];
        end
    end

    // pipeline advance and output serializer
    logic            ser_v_reg;
    logic [BW-1:0]   beat_reg;
    logic            fin_reg;
    logic [CB-1:0]   cx_reg, cy_reg;
    logic [CW-1:0]   col_reg;
    logic [RI-1:0]   ip_reg;
    logic [AW-1:0]   ain_reg, aout_reg;

    assign out_fire  = m_tvalid && m_tready;
    assign ser_free  = !ser_v_reg || (out_fire && beat_reg == LAST_BEAT);
    assign tail_take = v3_reg && (skip3_reg || ser_free);
    assign load      = v3_reg && !skip3_reg && ser_free;
    assign en        = !v3_reg || tail_take;
    assign s_tready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_v_reg <= 1'b0;
            beat_reg  <= '0;
        end else begin
            if (load) begin
                ser_v_reg <= 1'b1;
            end else if (out_fire && beat_reg == LAST_BEAT) begin
                ser_v_reg <= 1'b0;
            end
            if (out_fire) begin
                beat_reg <= beat_reg + BW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            fin_reg  <= fin3_reg;
            cx_reg   <= cx3_reg;
            cy_reg   <= cy3_reg;
            col_reg  <= col3_reg;
            ip_reg   <= ip3_reg;
            ain_reg  <= ain3_reg;
            aout_reg <= aout3_reg;
        end
    end

    // pixel of the current beat
    logic             outer, swap, xneg, yneg;
    logic [ARI_W-1:0] cxe, cye, cole, he, xoff, yoff, px, py;
    logic [AW-1:0]    cov;

    assign outer = beat_reg[BW-1];
    // points 4..7 and 12..15 swap the roles of column and height
    assign swap  = beat_reg[2];
    assign xneg  = beat_reg[1] ^ beat_reg[0];
    assign yneg  = beat_reg[1];
    assign cxe   = ARI_W'(signed'(cx_reg));
    assign cye   = ARI_W'(signed'(cy_reg));
    assign cole  = ARI_W'(col_reg);
    assign he    = ARI_W'(ip_reg) + ARI_W'(outer);
    assign xoff  = swap ? he : cole;
    assign yoff  = swap ? cole : he;
    assign px    = xneg ? (cxe - xoff) : (cxe + xoff);
    assign py    = yneg ? (cye - yoff) : (cye + yoff);
    assign cov   = outer ? aout_reg : ain_reg;

    assign m_tvalid = ser_v_reg;
    assign m_tdata  = OUT_TD_W'({cov, py[OUT_W-1:0], px[OUT_W-1:0]});
    assign m_tuser  = fin_reg;
    assign m_tlast  = (beat_reg == LAST_BEAT);

    logic [AW:0] alpha_sum;
    assign alpha_sum = {1'b0, ain_reg} + {1'b0, aout_reg};

    `AACOL_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, v1_reg, "accepted request lost at stage 1")
    `AACOL_ASSERT_NXT(a_tail_holds, v3_reg && !tail_take, v3_reg, "stalled column dropped at tail")
    `AACOL_ASSERT_NXT(a_load_starts, load, beat_reg == '0, "column does not start at first pixel")
    `AACOL_ASSERT_NXT(a_beat_holds, ser_v_reg && !m_tready, $stable(beat_reg), "pixel skipped under stall")
    `AACOL_ASSERT_IMP(a_alpha_pair, ser_v_reg, alpha_sum == 9'd255 || alpha_sum == 9'd254, "inner and outer coverage do not pair")

endmodule

/* src/aacol_sqrt_step.sv */
// one registered bit step of the pipelined integer square root
module aacol_sqrt_step #(
    parameter int ROOT_W = aacol_pkg::DEF_RADIUS_INT_BITS + aacol_pkg::DEF_RADIUS_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ROOT_W:0]       rem_in,
    input  logic [ROOT_W-1:0]     root_in,
    input  logic [2*ROOT_W-1:0]   rad_in,
    output logic [ROOT_W:0]       rem_out,
    output logic [ROOT_W-1:0]     root_out,
    output logic [2*ROOT_W-1:0]   rad_out
);

    localparam int SH_W = ROOT_W + 3;

    logic [SH_W-1:0] rem_sh;
    logic [SH_W-1:0] trial;
    logic [SH_W:0]   diff;
    logic            fits;

    logic [ROOT_W:0]     rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [2*ROOT_W-1:0] rad_reg;

    assign rem_sh = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
    assign trial  = SH_W'({root_in[ROOT_W-2:0], 2'b01});
    assign diff   = {1'b0, rem_sh} - {1'b0, trial};
    assign fits   = !diff[SH_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= fits ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
            root_reg <= {root_in[ROOT_W-2:0], fits};
            rad_reg  <= {rad_in[2*ROOT_W-3:0], 2'b00};
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;

endmodule
